/* rtl/core/noise_sphere_point_mapper_core_macros.svh */
// Assertion macros shared by the point mapper RTL.
`ifndef NOISE_SPHERE_POINT_MAPPER_CORE_MACROS_SVH
`define NOISE_SPHERE_POINT_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define NSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define NSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nsm_pkg.sv */
// Shared types, constants and table builders for the noise sphere point mapper.
package nsm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 15;

  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 11;
  localparam int MID_W   = 12;
  localparam int VIEW_W  = 2;
  localparam int OFF_W   = 13;   // screen offset, |off| <= 2047

  localparam int QUEUE_DEPTH = 2;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam int SIN_ENTRIES  = 129;  // quarter wave, both ends included
  localparam int ROOT_ENTRIES = 256;

  localparam logic [1:0] FILL_PRIMED = 2'd2;
  localparam logic [1:0] FILL_MAX    = 2'd3;

  // projections
  localparam logic [VIEW_W-1:0] VIEW_YZ = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_XY = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_ZX = 2'd2;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MID_A = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MID_B = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MID_C = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MID_Y = 3'd4;

  localparam logic [SCALE_W-1:0] SCALE_RST = 11'd106;
  localparam logic [MID_W-1:0]   MID_A_RST = 12'd106;
  localparam logic [MID_W-1:0]   MID_B_RST = 12'd318;
  localparam logic [MID_W-1:0]   MID_C_RST = 12'd530;
  localparam logic [MID_W-1:0]   MID_Y_RST = 12'd240;

  typedef struct packed {
    logic [BYTE_W-1:0] b_old;
    logic [BYTE_W-1:0] b_mid;
    logic [BYTE_W-1:0] b_new;
  } job_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [MID_W-1:0]   mid_a;
    logic [MID_W-1:0]   mid_b;
    logic [MID_W-1:0]   mid_c;
    logic [MID_W-1:0]   mid_y;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // round(sin(pi*k/256) * 2^frac), evaluated at elaboration
  function automatic int sin_entry(input int k, input int frac);
    real ang;
    ang = 3.14159265358979323846 * real'(k) / 256.0;
    return $rtoi($floor($sin(ang) * (2.0 ** frac) + 0.5));
  endfunction

  // round(sqrt(b/256) * 2^frac): bitwise integer root, then halve with rounding
  function automatic int root_entry(input int b, input int frac);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] probe;
    v     = 64'(b) << (2 * frac - 6);
    res   = '0;
    probe = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return int'((res + 64'd1) >> 1);
  endfunction

endpackage

/* rtl/core/nsm_ifs.sv */
// Valid/ready channel interfaces: byte input and screen point output.
interface nsm_byte_if import nsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

interface nsm_point_if import nsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VIEW_W-1:0]     view;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last;

  modport source (output valid, output view, output pixel_x, output pixel_y, output last,
                  input ready);
  modport sink   (input valid, input view, input pixel_x, input pixel_y, input last,
                  output ready);
endinterface

/* rtl/core/nsm_fifo.sv */
// Short job queue between the byte front end and the point back end.
`include "noise_sphere_point_mapper_core_macros.svh"

module nsm_fifo import nsm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  job_t   data_i,
  input  logic   pop_i,
  output job_t   data_o,
  output qstat_t stat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  `NSM_ASSERT_IMP(a_no_overflow, push_i, !stat_o.full, "job pushed into full queue")
  `NSM_ASSERT_IMP(a_no_underflow, pop_i, !stat_o.empty, "job popped from empty queue")
  `NSM_ASSERT_NXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

/* rtl/core/nsm_front.sv */
// Byte front end: keeps the byte window and queues one job per primed byte.
module nsm_front import nsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  nsm_byte_if.sink        byte_if,
  input  qstat_t          qstat_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [1:0]        fill_q, fill_d;
  logic [BYTE_W-1:0] older_q, newer_q;
  logic              primed;
  logic              accept;

  // with two bytes already seen, this byte completes a window
  assign primed = (fill_q >= FILL_PRIMED);

  // fill bytes never need queue space
  assign byte_if.ready = !(primed && qstat_i.full);
  assign accept        = byte_if.valid && byte_if.ready;
  assign push_o        = accept && primed;

  assign job_o.b_old = older_q;
  assign job_o.b_mid = newer_q;
  assign job_o.b_new = byte_if.sample_byte;

  assign fill_d = (accept && fill_q != FILL_MAX) ? fill_q + 1'b1 : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      older_q <= '0;
      newer_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        older_q <= newer_q;
        newer_q <= byte_if.sample_byte;
      end
    end
  end

endmodule

/* rtl/core/nsm_back.sv */
// Point back end: table lookups, product stages and the three-point emitter.
`include "noise_sphere_point_mapper_core_macros.svh"

module nsm_back import nsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         job_i,
  input  logic         job_valid_i,
  output logic         job_pop_o,
  input  cfg_t         cfg_i,
  nsm_point_if.source  point_if
);

  localparam int W     = FRAC_BITS + 2;          // trig / coordinate width
  localparam int PW    = 2 * W;                  // coordinate product
  localparam int SW    = W + SCALE_W + 2;        // scaled coordinate
  localparam int SUM_W = (COORD_BITS + 1 > MID_W + 2) ? COORD_BITS + 1 : MID_W + 2;

  localparam logic signed [W-1:0]     ONE    = W'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0]    HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]    HALF_S = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] TOP    = (SUM_W'(1) << COORD_BITS) - SUM_W'(1);

  // constant tables
  logic signed [W-1:0] sin_lut  [SIN_ENTRIES];
  logic signed [W-1:0] root_lut [ROOT_ENTRIES];

  for (genvar k = 0; k < SIN_ENTRIES; k++) begin : g_sin
    localparam int SIN_VAL = sin_entry(k, FRAC_BITS);
    assign sin_lut[k] = W'(SIN_VAL);
  end

  for (genvar k = 0; k < ROOT_ENTRIES; k++) begin : g_root
    localparam int ROOT_VAL = root_entry(k, FRAC_BITS);
    assign root_lut[k] = W'(ROOT_VAL);
  end

  // sin(pi*k/256), period 512, from the quarter wave
  function automatic logic signed [W-1:0] sin_look(input logic [8:0] k);
    logic [7:0]          idx;
    logic signed [W-1:0] mag;
    idx = k[7] ? (8'd128 - {1'b0, k[6:0]}) : {1'b0, k[6:0]};
    mag = sin_lut[idx];
    return k[8] ? -mag : mag;
  endfunction

  // floor(p / 2^F + 1/2)
  function automatic logic signed [W-1:0] round_half(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + HALF_P;
    return s[FRAC_BITS +: W];
  endfunction

  // w / 2^F truncated toward zero: floor plus one on a negative inexact value
  function automatic logic signed [OFF_W-1:0] trunc_off(input logic signed [SW-1:0] w);
    logic signed [SW-1:0] fl;
    logic                 inc;
    fl  = w >>> FRAC_BITS;
    inc = w[SW-1] && (|w[FRAC_BITS-1:0]);
    return fl[OFF_W-1:0] + OFF_W'(inc);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] s);
    if (s < 0) begin
      return '0;
    end else if (s > TOP) begin
      return '1;
    end
    return s[COORD_BITS-1:0];
  endfunction

  // stage registers
  logic                v0_q, v1_q, v2_q, v3_q, em_v_q;
  logic signed [W-1:0] r0_q, sp0_q, cp0_q, st0_q, ct0_q;
  logic signed [W-1:0] rs1_q, z1_q, st1_q, ct1_q;
  logic signed [W-1:0] x2_q, y2_q;
  logic signed [SW-1:0] wz2_q;
  logic signed [SW-1:0] wx3_q, wy3_q;
  logic signed [OFF_W-1:0] oz3_q;
  logic signed [OFF_W-1:0] ox_q, oy_q, oz_q;
  logic [VIEW_W-1:0]   em_view_q, em_view_d;

  logic adv0, adv1, adv2, adv3;
  logic em_done, em_step;
  logic signed [SCALE_W:0] scale_s;
  logic [8:0] k_sp, k_cp, k_st, k_ct;

  assign em_done = em_v_q && point_if.ready && (em_view_q == VIEW_ZX);
  assign em_step = em_v_q && point_if.ready && !em_done;

  // a stage moves on when the one after it is empty or moving too
  assign adv3      = v3_q && (!em_v_q || em_done);
  assign adv2      = v2_q && (!v3_q || adv3);
  assign adv1      = v1_q && (!v2_q || adv2);
  assign adv0      = v0_q && (!v1_q || adv1);
  assign job_pop_o = job_valid_i && (!v0_q || adv0);

  assign scale_s = $signed({1'b0, cfg_i.scale});

  assign k_sp = {job_i.b_old, 1'b0};
  assign k_cp = {job_i.b_old, 1'b0} + 9'd128;
  assign k_st = {1'b0, job_i.b_mid};
  assign k_ct = {1'b0, job_i.b_mid} + 9'd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      em_v_q    <= 1'b0;
      em_view_q <= VIEW_YZ;
    end else begin
      v0_q      <= job_pop_o ? 1'b1 : (adv0 ? 1'b0 : v0_q);
      v1_q      <= adv0 ? 1'b1 : (adv1 ? 1'b0 : v1_q);
      v2_q      <= adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_q);
      v3_q      <= adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_q);
      em_v_q    <= adv3 ? 1'b1 : (em_done ? 1'b0 : em_v_q);
      em_view_q <= em_view_d;
    end
  end

  always_comb begin
    em_view_d = em_view_q;
    if (adv3) begin
      em_view_d = VIEW_YZ;
    end else if (em_step) begin
      em_view_d = em_view_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      r0_q  <= root_lut[job_i.b_new];
      sp0_q <= sin_look(k_sp);
      cp0_q <= sin_look(k_cp);
      st0_q <= sin_look(k_st);
      ct0_q <= sin_look(k_ct);
    end
    if (adv0) begin
      rs1_q <= round_half(PW'(r0_q) * PW'(sp0_q));
      z1_q  <= round_half(PW'(r0_q) * PW'(cp0_q));
      st1_q <= st0_q;
      ct1_q <= ct0_q;
    end
    if (adv1) begin
      x2_q  <= round_half(PW'(rs1_q) * PW'(ct1_q));
      y2_q  <= round_half(PW'(rs1_q) * PW'(st1_q));
      wz2_q <= SW'(scale_s) * SW'(z1_q) + HALF_S;
    end
    if (adv2) begin
      wx3_q <= SW'(scale_s) * SW'(x2_q) + HALF_S;
      wy3_q <= SW'(scale_s) * SW'(y2_q) + HALF_S;
      oz3_q <= trunc_off(wz2_q);
    end
    if (adv3) begin
      ox_q <= trunc_off(wx3_q);
      oy_q <= trunc_off(wy3_q);
      oz_q <= oz3_q;
    end
  end

  // point of the current view
  logic [MID_W-1:0]         mid_h;
  logic signed [OFF_W-1:0]  off_h, off_v;
  logic signed [SUM_W-1:0]  sum_h, sum_v;

  always_comb begin
    case (em_view_q)
      VIEW_YZ: begin
        mid_h = cfg_i.mid_a;
        off_h = oy_q;
        off_v = oz_q;
      end
      VIEW_XY: begin
        mid_h = cfg_i.mid_b;
        off_h = ox_q;
        off_v = oy_q;
      end
      VIEW_ZX: begin
        mid_h = cfg_i.mid_c;
        off_h = oz_q;
        off_v = ox_q;
      end
      default: begin
        mid_h = cfg_i.mid_a;
        off_h = oy_q;
        off_v = oz_q;
      end
    endcase
    sum_h = SUM_W'($signed({1'b0, mid_h})) + SUM_W'(off_h);
    sum_v = SUM_W'($signed({1'b0, cfg_i.mid_y})) - SUM_W'(off_v);
  end

  assign point_if.valid   = em_v_q;
  assign point_if.view    = em_view_q;
  assign point_if.pixel_x = clamp(sum_h);
  assign point_if.pixel_y = clamp(sum_v);
  assign point_if.last    = (em_view_q == VIEW_ZX);

  `NSM_ASSERT_IMP(a_view_code, em_v_q, em_view_q == VIEW_YZ || em_view_q == VIEW_XY || em_view_q == VIEW_ZX, "bad view code")
  `NSM_ASSERT_NXT(a_emit_drains, em_done && !adv3, !em_v_q, "emitter held after last point")
  `NSM_ASSERT_IMP(a_rs_bound, v1_q, rs1_q <= ONE && rs1_q >= -ONE, "r*sin(phi) off the unit range")

endmodule

/* rtl/core/noise_sphere_point_mapper_core.sv */
// Top level of the noise sphere point mapper: register port, front end, queue, back end.
//
//   channel   dir  handshake           payload
//   byte_if   in   valid/ready         sample_byte[7:0]
//   point_if  out  valid/ready         view[1:0], pixel_x, pixel_y, last
//   apb       in   psel/penable/pready scale, mid_a, mid_b, mid_c, mid_y
//
// A byte that completes a window yields three points at the point port, one point per
// cycle unless the port stalls; the single point emitter sets that rate. Window-fill
// bytes need no queue space. The first point of a byte is registered in turn in the
// queue, lookup, two product stages, scaling and emitter load before it is valid.
// Reset is asynchronous, active low; no clearing pass, bytes are taken right away.
// A stalled point port backs up the stages, then the queue, then byte_if.ready.
module noise_sphere_point_mapper_core import nsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nsm_byte_if.sink          byte_if,
  nsm_point_if.source       point_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // Register file: word addresses, index in paddr[4:2]; low address bits ignored
  // ---------------------------------------------------------------------------
  cfg_t                 cfg_q, cfg_d;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_SCALE: cfg_d.scale = pwdata[SCALE_W-1:0];
        REG_MID_A: cfg_d.mid_a = pwdata[MID_W-1:0];
        REG_MID_B: cfg_d.mid_b = pwdata[MID_W-1:0];
        REG_MID_C: cfg_d.mid_c = pwdata[MID_W-1:0];
        REG_MID_Y: cfg_d.mid_y = pwdata[MID_W-1:0];
        default:   cfg_d = cfg_q;   // unmapped: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale <= SCALE_RST;
      cfg_q.mid_a <= MID_A_RST;
      cfg_q.mid_b <= MID_B_RST;
      cfg_q.mid_c <= MID_C_RST;
      cfg_q.mid_y <= MID_Y_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE: prdata = APB_DW'(cfg_q.scale);
      REG_MID_A: prdata = APB_DW'(cfg_q.mid_a);
      REG_MID_B: prdata = APB_DW'(cfg_q.mid_b);
      REG_MID_C: prdata = APB_DW'(cfg_q.mid_c);
      REG_MID_Y: prdata = APB_DW'(cfg_q.mid_y);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end -> job queue -> back end
  // ---------------------------------------------------------------------------
  qstat_t qstat;
  logic   push;
  logic   pop;
  job_t   job_in;
  job_t   job_out;

  nsm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_if (byte_if),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (job_in)
  );

  nsm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (qstat)
  );

  // the back end reads the live registers; the user must change them only while idle, the block does not enforce it
  nsm_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (!qstat.empty),
    .job_pop_o   (pop),
    .cfg_i       (cfg_q),
    .point_if    (point_if)
  );

endmodule
